// ===== src/wmjc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmjc_pkg
// Shared types and constants for the windowed minimum jump cost unit.
// ----------------------------------------------------------------------------
package wmjc_pkg;

  localparam int HEIGHT_W = 16;
  localparam int COST_W   = 48;
  localparam int WINDOW_W = 8;

  // Largest cost. Every sum clamps here.
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Window value after reset.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(2);

  // One ring entry: the height of an earlier stone and its cost.
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [COST_W-1:0]   cost;
  } entry_t;

endpackage
`default_nettype wire

// ===== src/wmjc_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmjc interfaces
// Valid/ready channels for stone heights in and stone costs out.
// ----------------------------------------------------------------------------
interface wmjc_stone_if;
  logic                          valid;
  logic                          ready;
  logic [wmjc_pkg::HEIGHT_W-1:0] height;
  logic                          start_of_sequence;

  modport source (output valid, output height, output start_of_sequence, input ready);
  modport sink   (input valid, input height, input start_of_sequence, output ready);
endinterface

interface wmjc_cost_if;
  logic                        valid;
  logic                        ready;
  logic [wmjc_pkg::COST_W-1:0] cost;

  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface
`default_nettype wire

// ===== src/wmjc_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmjc_ring
// Ring memory of earlier stones: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module wmjc_ring #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire wmjc_pkg::entry_t  wentry,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output wmjc_pkg::entry_t       rentry
);

  wmjc_pkg::entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rentry <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/wmjc_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmjc_seq
// Sequencer for one stone: walks back through the ring one entry a cycle,
// keeps the running minimum of cost plus height difference, then writes the
// new stone into the ring and hands its cost on.
// ----------------------------------------------------------------------------
module wmjc_seq #(
  parameter int MAX_WINDOW = 128,
  parameter int SLOT_W     = 7,
  parameter int CNT_W      = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [CNT_W-1:0]              window,
  input  wire logic                          stone_valid,
  output logic                               stone_ready,
  input  wire logic [wmjc_pkg::HEIGHT_W-1:0] stone_height,
  input  wire logic                          stone_start,
  input  wire logic                          out_free,
  output logic                               done,
  output logic [wmjc_pkg::COST_W-1:0]        done_cost,
  output logic                               ring_we,
  output logic [SLOT_W-1:0]                  ring_waddr,
  output wmjc_pkg::entry_t                   ring_wentry,
  output logic                               ring_re,
  output logic [SLOT_W-1:0]                  ring_raddr,
  input  wire wmjc_pkg::entry_t              ring_rentry
);

  typedef enum logic [1:0] {
    IDLE,
    READ,
    WRITE
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);
  localparam logic [CNT_W-1:0]  HELD_MAX  = CNT_W'(MAX_WINDOW);

  state_t                        state;
  logic [SLOT_W-1:0]             write_slot;
  logic [CNT_W-1:0]              stones_held;
  logic [wmjc_pkg::HEIGHT_W-1:0] cur_height;
  logic [CNT_W-1:0]              issue_left;
  logic [SLOT_W-1:0]             rd_ptr;
  logic                          rd_pending;
  logic [wmjc_pkg::COST_W-1:0]   best;

  logic                          accept;
  logic [CNT_W-1:0]              held_now;
  logic [CNT_W-1:0]              span;
  logic [SLOT_W-1:0]             prev_slot;
  logic [SLOT_W-1:0]             prev_ptr;
  logic [SLOT_W-1:0]             next_slot;
  logic [wmjc_pkg::HEIGHT_W-1:0] diff;
  logic [wmjc_pkg::COST_W:0]     sum;
  logic [wmjc_pkg::COST_W-1:0]   cand;

  // Handshake and ring port decode.
  assign stone_ready = (state == IDLE);
  assign accept      = stone_valid && stone_ready;
  assign ring_re     = (state == READ) && (issue_left != '0);
  assign ring_raddr  = rd_ptr;
  assign ring_we     = (state == WRITE) && out_free;
  assign ring_waddr  = write_slot;
  assign ring_wentry = '{height: cur_height, cost: best};
  assign done        = ring_we;
  assign done_cost   = best;

  // A start mark drops the stones held; the walk spans the smaller of the
  // stones held and the window.
  assign held_now = stone_start ? '0 : stones_held;
  assign span     = (held_now < window) ? held_now : window;

  // Ring pointer steps with wrap at the ring depth.
  assign prev_slot = (write_slot == '0) ? LAST_SLOT : write_slot - SLOT_W'(1);
  assign prev_ptr  = (rd_ptr == '0) ? LAST_SLOT : rd_ptr - SLOT_W'(1);
  assign next_slot = (write_slot == LAST_SLOT) ? '0 : write_slot + SLOT_W'(1);

  // Candidate cost of the jump from the entry just read, clamped at the top.
  assign diff = (cur_height > ring_rentry.height) ? cur_height - ring_rentry.height
                                                  : ring_rentry.height - cur_height;
  assign sum  = {1'b0, ring_rentry.cost} + (wmjc_pkg::COST_W + 1)'(diff);
  assign cand = sum[wmjc_pkg::COST_W] ? wmjc_pkg::COST_MAX : sum[wmjc_pkg::COST_W-1:0];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      write_slot  <= '0;
      stones_held <= '0;
      issue_left  <= '0;
      rd_pending  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          rd_pending <= 1'b0;
          if (accept) begin
            cur_height  <= stone_height;
            stones_held <= held_now;
            rd_ptr      <= prev_slot;
            issue_left  <= span;
            if (span == '0) begin
              best  <= '0;
              state <= WRITE;
            end else begin
              best  <= wmjc_pkg::COST_MAX;
              state <= READ;
            end
          end
        end
        READ: begin
          rd_pending <= ring_re;
          if (ring_re) begin
            rd_ptr     <= prev_ptr;
            issue_left <= issue_left - CNT_W'(1);
          end
          if (rd_pending && (cand < best)) begin
            best <= cand;
          end
          if ((issue_left == '0) && !rd_pending) begin
            state <= WRITE;
          end
        end
        WRITE: begin
          if (out_free) begin
            write_slot <= next_slot;
            if (stones_held != HELD_MAX) begin
              stones_held <= stones_held + CNT_W'(1);
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/windowed_min_jump_cost_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_min_jump_cost_unit
// Least total jump cost to each stone of a stream, over a configurable window.
// ----------------------------------------------------------------------------
// One stone is worked on at a time. A stone reads min(window, stones held)
// earlier entries, none for the first stone of a sequence, before its cost is
// written to the ring and the output register; the single read port of the
// ring memory returns one earlier height and cost per cycle. The next stone is
// taken while a cost still waits at the output. Write the window register with
// cfg_we and cfg_wdata only while the unit is idle; the block itself does not
// enforce this. A window of zero acts as one and a window above MAX_WINDOW acts
// as MAX_WINDOW. Costs clamp at 2^48-1. The ring needs no clearing pass after
// reset: only entries of the current sequence are read.
// ----------------------------------------------------------------------------
module windowed_min_jump_cost_unit #(
  parameter int MAX_WINDOW = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [wmjc_pkg::WINDOW_W-1:0] cfg_wdata,
  wmjc_stone_if.sink                         stone,
  wmjc_cost_if.source                        result
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (CNT_W > wmjc_pkg::WINDOW_W) ? CNT_W : wmjc_pkg::WINDOW_W;

  logic [wmjc_pkg::WINDOW_W-1:0] jump_window;
  logic [CMP_W-1:0]              window_wide;
  logic [CNT_W-1:0]              window_eff;
  logic                          out_free;
  logic                          done;
  logic [wmjc_pkg::COST_W-1:0]   done_cost;
  logic                          ring_we;
  logic [SLOT_W-1:0]             ring_waddr;
  wmjc_pkg::entry_t              ring_wentry;
  logic                          ring_re;
  logic [SLOT_W-1:0]             ring_raddr;
  wmjc_pkg::entry_t              ring_rentry;

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_window <= wmjc_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      jump_window <= cfg_wdata;
    end
  end

  // Effective window: at least one, at most the ring depth.
  assign window_wide = (jump_window == '0) ? CMP_W'(1) : CMP_W'(jump_window);
  assign window_eff  = (window_wide > CMP_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                         : CNT_W'(window_wide);

  // Output register: free when empty or when its item is taken this cycle.
  assign out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result.cost <= done_cost;
    end
  end

  wmjc_seq #(
    .MAX_WINDOW (MAX_WINDOW),
    .SLOT_W     (SLOT_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .window       (window_eff),
    .stone_valid  (stone.valid),
    .stone_ready  (stone.ready),
    .stone_height (stone.height),
    .stone_start  (stone.start_of_sequence),
    .out_free     (out_free),
    .done         (done),
    .done_cost    (done_cost),
    .ring_we      (ring_we),
    .ring_waddr   (ring_waddr),
    .ring_wentry  (ring_wentry),
    .ring_re      (ring_re),
    .ring_raddr   (ring_raddr),
    .ring_rentry  (ring_rentry)
  );

  wmjc_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk    (clk),
    .we     (ring_we),
    .waddr  (ring_waddr),
    .wentry (ring_wentry),
    .re     (ring_re),
    .raddr  (ring_raddr),
    .rentry (ring_rentry)
  );

endmodule
`default_nettype wire

// ===== src/wmjc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmjc_checker
// Port-level checks on the jump cost unit, bound to its top level.
// ----------------------------------------------------------------------------
module wmjc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        stone_valid,
  input wire logic                        stone_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [wmjc_pkg::COST_W-1:0] result_cost
);

  logic [1:0] outstanding;
  logic       stone_acc;
  logic       result_acc;

  assign stone_acc  = stone_valid && stone_ready;
  assign result_acc = result_valid && result_ready;

  // Items accepted whose cost has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (stone_acc && !result_acc) begin
      outstanding <= outstanding + 2'd1;
    end else if (result_acc && !stone_acc) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  // A stalled cost stays offered.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_cost))
    else $error("stalled cost item dropped or changed");

  // One stone at a time: input closes right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    stone_acc |=> !stone_ready)
    else $error("stone accepted while the previous one is in work");

  // No cost without an accepted stone behind it.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 2'd0)
    else $error("cost offered with no stone outstanding");

  // At most one stone in work and one cost waiting.
  assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more stones outstanding than the unit can hold");

  // Reset empties the output.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("cost offered right after reset");

endmodule

bind windowed_min_jump_cost_unit wmjc_checker u_wmjc_checker (
  .clk          (clk),
  .rst          (rst),
  .stone_valid  (stone.valid),
  .stone_ready  (stone.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_cost  (result.cost)
);
`default_nettype wire

// ===== bench/tb_windowed_min_jump_cost_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_min_jump_cost_unit
// Self-checking bench for the windowed minimum jump cost unit. A scoreboard
// keeps its own rings of earlier heights and costs, works out the least cost
// of every accepted stone and checks the costs in order. The stimulus covers
// height extremes and the window corner values, then runs random sequences
// under random sender bursts and receiver stalls, with one long stall.
// ----------------------------------------------------------------------------
module tb_windowed_min_jump_cost_unit;

  localparam int RING_DEPTH = 128;
  localparam int LONG_HOLD  = 400;
  localparam int STONE_GOAL = 1850;

  typedef enum int {HS_SPREAD, HS_WALK, HS_EXTREME, HS_FLAT} height_style_t;

  // Tracks the stones of the current sequence and the costs still owed.
  class stone_cost_board_t;
    logic [wmjc_pkg::WINDOW_W-1:0] window;
    logic [wmjc_pkg::HEIGHT_W-1:0] ring_h [RING_DEPTH];
    logic [wmjc_pkg::COST_W-1:0]   ring_c [RING_DEPTH];
    int                            slot_next;
    int                            held;
    logic [wmjc_pkg::COST_W-1:0]   owed_costs [$];
    int                            mismatches;

    function new();
      window     = wmjc_pkg::WINDOW_RESET;
      slot_next  = 0;
      held       = 0;
      mismatches = 0;
      foreach (ring_h[i]) begin
        ring_h[i] = '0;
        ring_c[i] = '0;
      end
    endfunction

    // Works out the least cost of an accepted stone and records it.
    function void take_stone(logic [wmjc_pkg::HEIGHT_W-1:0] h, logic sos);
      int                            span;
      int                            reach;
      int                            slot;
      logic [wmjc_pkg::HEIGHT_W-1:0] diff;
      logic [wmjc_pkg::COST_W:0]     sum;
      logic [wmjc_pkg::COST_W-1:0]   best;
      if (sos) held = 0;
      span  = (window == 0) ? 1 : ((window > RING_DEPTH) ? RING_DEPTH : int'(window));
      reach = (held < span) ? held : span;
      best  = '0;
      if (reach > 0) begin
        best = wmjc_pkg::COST_MAX;
        for (int j = 1; j <= reach; j++) begin
          slot = (slot_next + RING_DEPTH - j) % RING_DEPTH;
          diff = (h > ring_h[slot]) ? h - ring_h[slot] : ring_h[slot] - h;
          sum  = {1'b0, ring_c[slot]} + diff;
          if (sum > wmjc_pkg::COST_MAX) sum = {1'b0, wmjc_pkg::COST_MAX};
          if (sum[wmjc_pkg::COST_W-1:0] < best) best = sum[wmjc_pkg::COST_W-1:0];
        end
      end
      ring_h[slot_next] = h;
      ring_c[slot_next] = best;
      slot_next = (slot_next + 1) % RING_DEPTH;
      if (held < RING_DEPTH) held++;
      owed_costs.push_back(best);
    endfunction

    // Compares a delivered cost with the oldest one owed.
    function void match_cost(logic [wmjc_pkg::COST_W-1:0] actual);
      logic [wmjc_pkg::COST_W-1:0] owed;
      if (owed_costs.size() == 0) begin
        $display("%0t: unexpected cost, expected none, got %0d", $time, actual);
        mismatches++;
      end else begin
        owed = owed_costs.pop_front();
        if (actual !== owed) begin
          $display("%0t: cost mismatch, expected %0d, got %0d", $time, owed, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return owed_costs.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we;
  logic [wmjc_pkg::WINDOW_W-1:0] cfg_wdata;
  int                            hold_requests = 0;

  wmjc_stone_if stone_ch ();
  wmjc_cost_if  cost_ch ();

  stone_cost_board_t board;
  bit                offering;
  int                burst_left;
  int                stones_sent;

  windowed_min_jump_cost_unit #(
    .MAX_WINDOW (RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stone     (stone_ch),
    .result    (cost_ch)
  );

  // Clock generation, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one stone, waits for it to be taken, then keeps or breaks the burst.
  task automatic offer_stone(logic [wmjc_pkg::HEIGHT_W-1:0] h, logic sos);
    int gap;
    stone_ch.valid             <= 1'b1;
    stone_ch.height            <= h;
    stone_ch.start_of_sequence <= sos;
    offering = 1'b1;
    do @(posedge clk); while (!stone_ch.ready);
    board.take_stone(h, sos);
    stones_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      stone_ch.valid <= 1'b0;
      offering = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Stops offering and waits until every owed cost has been delivered.
  task automatic wait_drained();
    if (offering) begin
      stone_ch.valid <= 1'b0;
      offering = 1'b0;
      burst_left = 0;
    end
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Writes the window register once the unit has gone idle.
  task automatic set_window(logic [wmjc_pkg::WINDOW_W-1:0] w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.window = w;
  endtask

  function automatic logic [wmjc_pkg::HEIGHT_W-1:0] next_height(
    height_style_t style, logic [wmjc_pkg::HEIGHT_W-1:0] prev);
    int v;
    v = int'(prev) + $urandom_range(0, 600) - 300;
    case (style)
      HS_SPREAD:  return wmjc_pkg::HEIGHT_W'($urandom);
      HS_WALK: begin
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return wmjc_pkg::HEIGHT_W'(v);
      end
      HS_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:    return prev;
    endcase
  endfunction

  // Random sequences, mostly opened with a start mark.
  task automatic run_phase(int count);
    int                            left;
    int                            len;
    height_style_t                 style;
    logic [wmjc_pkg::HEIGHT_W-1:0] h;
    logic                          sos;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 19))
        0:       len = 1;
        1, 2, 3: len = $urandom_range(41, 300);
        default: len = $urandom_range(2, 40);
      endcase
      if (len > left) len = left;
      style = height_style_t'($urandom_range(0, 3));
      h = wmjc_pkg::HEIGHT_W'($urandom);
      for (int i = 0; i < len; i++) begin
        sos = (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
        if (i > 0) h = next_height(style, h);
        offer_stone(h, sos);
      end
      left -= len;
    end
  endtask

  // Result receiver: stalls on random 32-bit ready patterns, plus one long hold-off.
  initial begin : cost_sink
    int          hold_left;
    int          seen;
    int          beat;
    logic [31:0] pattern;
    hold_left = 0;
    seen      = 0;
    beat      = 0;
    pattern   = '1;
    cost_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seen != hold_requests) begin
        seen      = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        cost_ch.ready <= 1'b0;
      end else begin
        if (beat == 0) begin
          case ($urandom_range(0, 3))
            0:       pattern = '1;
            1:       pattern = $urandom | $urandom;
            2:       pattern = $urandom;
            default: pattern = ($urandom & $urandom) | 32'h1;
          endcase
        end
        cost_ch.ready <= pattern[beat];
        beat = (beat + 1) % 32;
      end
    end
  end

  // Checks every cost taken by the receiver.
  always @(posedge clk) begin
    if (!rst && cost_ch.valid && cost_ch.ready) board.match_cost(cost_ch.cost);
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int                            phase_no;
    int                            count;
    logic [wmjc_pkg::WINDOW_W-1:0] w;
    cfg_we                     <= 1'b0;
    cfg_wdata                  <= '0;
    stone_ch.valid             <= 1'b0;
    stone_ch.height            <= '0;
    stone_ch.start_of_sequence <= 1'b0;
    offering    = 1'b0;
    burst_left  = 0;
    stones_sent = 0;
    board       = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset window of two; the first stone carries no start mark.
    offer_stone(16'hFFFF, 1'b0);
    offer_stone(16'h0000, 1'b0);
    offer_stone(16'hFFFF, 1'b0);
    offer_stone(16'h0001, 1'b0);
    offer_stone(16'hAAAA, 1'b0);
    offer_stone(16'h5555, 1'b0);
    offer_stone(16'h8000, 1'b0);
    offer_stone(16'h7FFF, 1'b0);
    offer_stone(16'h0000, 1'b1);
    offer_stone(16'hFFFF, 1'b0);
    offer_stone(16'hFFFF, 1'b0);
    offer_stone(16'h0000, 1'b0);

    // A window of zero behaves as one.
    set_window(8'd0);
    offer_stone(16'h0000, 1'b1);
    offer_stone(16'hFFFF, 1'b0);
    offer_stone(16'h0000, 1'b0);
    offer_stone(16'h0064, 1'b0);

    // A window above capacity behaves as the ring depth.
    set_window(8'd255);
    offer_stone(16'hFFFF, 1'b1);
    offer_stone(16'h0000, 1'b0);
    offer_stone(16'hFFFF, 1'b0);
    offer_stone(16'h1234, 1'b0);
    offer_stone(16'hFEDC, 1'b0);
    offer_stone(16'h0000, 1'b1);
    offer_stone(16'h0001, 1'b0);
    offer_stone(16'hFFFE, 1'b0);

    // Random phases over a spread of windows; most phases use small ones.
    phase_no = 0;
    while (stones_sent < STONE_GOAL) begin
      case (phase_no)
        0:       w = 8'd128;
        1:       w = 8'd129;
        2:       w = 8'd1;
        3:       w = 8'd255;
        4:       w = 8'd3;
        default: begin
          case ($urandom_range(0, 9))
            0:       w = wmjc_pkg::WINDOW_W'($urandom_range(65, 255));
            1, 2:    w = wmjc_pkg::WINDOW_W'($urandom_range(13, 64));
            3:       w = 8'd0;
            default: w = wmjc_pkg::WINDOW_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      set_window(w);
      if (phase_no < 2) count = 300;
      else if (w > 32) count = $urandom_range(40, 80);
      else count = $urandom_range(80, 200);
      // One long receiver hold-off while stones keep coming.
      if (phase_no == 4) hold_requests <= hold_requests + 1;
      run_phase(count);
      phase_no++;
    end

    wait_drained();
    repeat (RING_DEPTH + 8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin : watchdog
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
